// ===== rtl/lcs_pkg.sv =====
// ----------------------------------------------------------------------------
// lcs_pkg: light curve statistics types
// Payload structs for the point input and the statistics result.
// ----------------------------------------------------------------------------
`default_nettype none

package lcs_pkg;

  localparam int FLUX_W = 24;
  localparam int ERR_W  = 23;
  localparam int FRAC_W = 16;
  localparam int PC_W   = 11;
  localparam int STAT_W = 63;

  typedef struct packed {
    logic signed [FLUX_W-1:0] flux;
    logic [ERR_W-1:0]         flux_err;
    logic                     has_point;
    logic                     last;
  } lcs_in_t;

  typedef struct packed {
    logic [PC_W-1:0]          point_count;
    logic signed [FLUX_W-1:0] mean_flux;
    logic                     mean_valid;
    logic [STAT_W-1:0]        flux_variance;
    logic [STAT_W-1:0]        variability_index;
    logic                     weight_saturated;
  } lcs_out_t;

endpackage

`default_nettype wire

// ===== rtl/light_curve_statistics.sv =====
// ----------------------------------------------------------------------------
// light_curve_statistics: weighted chi-square variability index
// Accumulates flux points, emits mean, variance and variability index.
// ----------------------------------------------------------------------------
// Sequencing: a point holds the block for 12 sequencer steps plus a 33-step
// weight division; with a zero or unit denominator, 11 steps and no division.
// Closing a curve adds up to two 64-step and two 128-step divisions and two
// 3-product squares on the shared divider and multiplier.
// One item at a time: a new input is taken only in S_IDLE.
// Reset (rst_ni low, async): accumulators and the fraction register clear.
`default_nettype none

module light_curve_statistics
  import lcs_pkg::*;
#(
  parameter int MAX_POINTS = 1024
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [FRAC_W-1:0] cfg_data_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire lcs_in_t           in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output lcs_out_t               out_data_o
);

  // accumulator widths follow the point limit
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int SF_W  = CNT_W + 24;
  localparam int SQ_W  = CNT_W + 47;
  localparam int SW_W  = CNT_W + 32;

  typedef enum logic [4:0] {
    S_IDLE, P_SYS, P_E2, P_S2, P_DEN, P_W, P_WDONE, P_M1, P_M2, P_M3, P_M4,
    P_M5, P_ACC, S_DIV, SQ_A, SQ_B, SQ_C, SQ_D, F_START, F_MEAN_DONE,
    F_VAR_Q, F_VAR_DIFF, F_VAR_DONE, F_IDX, F_IDX_Q, F_IDX_DONE, F_OUT
  } state_e;

  state_e               state_q, ret_q;
  lcs_in_t              in_q;
  logic [FRAC_W-1:0]    frac_q;
  logic [63:0]          p_q;
  logic [23:0]          sys_q;
  logic [47:0]          den_q;
  logic [31:0]          w_q;
  logic [46:0]          f2_q;
  logic signed [55:0]   wf_q;
  logic [63:0]          wf2_q;
  // shared restoring divider
  logic [127:0]         dv_q;
  logic [63:0]          rem_q;
  logic [63:0]          dsr_q;
  logic [7:0]           dcnt_q;
  // shared squarer accumulator
  logic [63:0]          x_q;
  logic [127:0]         acc_q;
  // accumulators
  logic [CNT_W-1:0]     count_q;
  logic signed [SF_W-1:0] sum_flux_q;
  logic [SQ_W-1:0]      sum_flux_sq_q;
  logic [SW_W-1:0]      sum_w_q;
  logic [63:0]          sum_wf_q;
  logic [63:0]          sum_wf2_q;
  logic                 sat_q;
  // result
  logic [23:0]          mean_q;
  logic [62:0]          var_q;
  logic [63:0]          idx_q;
  logic                 out_valid_q;
  lcs_out_t             out_q;

  logic [23:0]          mag;
  logic [31:0]          mul_a, mul_b;
  logic [64:0]          rem_sh;
  logic                 q_bit;
  logic [63:0]          sf_mag, swf_mag, q64, sxx64, idx_new;
  logic signed [64:0]   swf_sum;
  logic [64:0]          swf2_sum;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign mag     = in_q.flux[23] ? 24'(~in_q.flux + 24'd1) : in_q.flux;
  assign sf_mag  = sum_flux_q[SF_W-1] ? 64'(-sum_flux_q) : 64'(sum_flux_q);
  assign swf_mag = sum_wf_q[63] ? (64'd0 - sum_wf_q) : sum_wf_q;
  assign sxx64   = 64'(sum_flux_sq_q);
  assign q64     = (|dv_q[127:80]) ? {64{1'b1}} : dv_q[79:16];
  assign idx_new = (sum_wf2_q > q64) ? (sum_wf2_q - q64) : 64'd0;

  // one divider step: shift in next dividend bit, subtract when it fits
  assign rem_sh = {rem_q, dv_q[127]};
  assign q_bit  = (rem_sh >= {1'b0, dsr_q});

  // saturating sums for the weighted flux terms
  assign swf_sum  = $signed({sum_wf_q[63], sum_wf_q}) + 65'(wf_q);
  assign swf2_sum = {1'b0, sum_wf2_q} + {1'b0, wf2_q};

  // shared multiplier operand select
  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    case (state_q)
      P_SYS: begin mul_a = 32'(frac_q); mul_b = 32'(mag); end
      P_E2:  begin mul_a = 32'(in_q.flux_err); mul_b = 32'(in_q.flux_err); end
      P_S2:  begin mul_a = 32'(sys_q); mul_b = 32'(sys_q); end
      P_M1:  begin mul_a = 32'(mag); mul_b = 32'(mag); end
      P_M2:  begin mul_a = w_q; mul_b = 32'(mag); end
      P_M3:  begin mul_a = w_q; mul_b = 32'(f2_q[46:16]); end
      P_M4:  begin mul_a = w_q; mul_b = 32'(f2_q[15:0]); end
      SQ_A:  begin mul_a = x_q[31:0]; mul_b = x_q[31:0]; end
      SQ_B:  begin mul_a = x_q[31:0]; mul_b = x_q[63:32]; end
      SQ_C:  begin mul_a = x_q[63:32]; mul_b = x_q[63:32]; end
      default: begin mul_a = 32'd0; mul_b = 32'd0; end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      ret_q         <= S_IDLE;
      in_q          <= '0;
      frac_q        <= '0;
      p_q           <= '0;
      sys_q         <= '0;
      den_q         <= '0;
      w_q           <= '0;
      f2_q          <= '0;
      wf_q          <= '0;
      wf2_q         <= '0;
      dv_q          <= '0;
      rem_q         <= '0;
      dsr_q         <= '0;
      dcnt_q        <= '0;
      x_q           <= '0;
      acc_q         <= '0;
      count_q       <= '0;
      sum_flux_q    <= '0;
      sum_flux_sq_q <= '0;
      sum_w_q       <= '0;
      sum_wf_q      <= '0;
      sum_wf2_q     <= '0;
      sat_q         <= 1'b0;
      mean_q        <= '0;
      var_q         <= '0;
      idx_q         <= '0;
      out_valid_q   <= 1'b0;
      out_q         <= '0;
    end else begin
      p_q <= 64'(mul_a) * 64'(mul_b);
      if (cfg_valid_i) begin
        frac_q <= cfg_data_i;
      end
      // F_OUT reloads the output register itself
      if (out_valid_q && out_ready_i && (state_q != F_OUT)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            in_q <= in_data_i;
            if (in_data_i.has_point && (count_q < CNT_W'(MAX_POINTS))) begin
              state_q <= P_SYS;
            end else if (in_data_i.last) begin
              state_q <= F_START;
            end
          end
        end
        // ---- per point weight and products
        P_SYS: state_q <= P_E2;
        P_E2: begin
          sys_q   <= p_q[39:16];
          state_q <= P_S2;
        end
        P_S2: begin
          den_q   <= p_q[47:0];
          state_q <= P_DEN;
        end
        P_DEN: begin
          den_q   <= den_q + p_q[47:0];
          state_q <= P_W;
        end
        P_W: begin
          if (den_q <= 48'd1) begin
            w_q     <= {32{1'b1}};
            sat_q   <= 1'b1;
            state_q <= P_M1;
          end else begin
            dv_q    <= {1'b1, 127'd0};
            rem_q   <= '0;
            dsr_q   <= 64'(den_q);
            dcnt_q  <= 8'd33;
            ret_q   <= P_WDONE;
            state_q <= S_DIV;
          end
        end
        P_WDONE: begin
          w_q     <= dv_q[31:0];
          state_q <= P_M1;
        end
        P_M1: state_q <= P_M2;
        P_M2: begin
          f2_q    <= p_q[46:0];
          state_q <= P_M3;
        end
        P_M3: begin
          wf_q    <= in_q.flux[23] ? -$signed({1'b0, p_q[54:0]})
                                   : $signed({1'b0, p_q[54:0]});
          state_q <= P_M4;
        end
        P_M4: begin
          wf2_q   <= p_q;
          state_q <= P_M5;
        end
        P_M5: begin
          wf2_q   <= wf2_q + {16'd0, p_q[63:16]};
          state_q <= P_ACC;
        end
        P_ACC: begin
          count_q       <= count_q + CNT_W'(1);
          sum_flux_q    <= sum_flux_q + SF_W'(in_q.flux);
          sum_flux_sq_q <= sum_flux_sq_q + SQ_W'(f2_q);
          sum_w_q       <= sum_w_q + SW_W'(w_q);
          if (swf_sum[64] != swf_sum[63]) begin
            sum_wf_q <= swf_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
          end else begin
            sum_wf_q <= swf_sum[63:0];
          end
          sum_wf2_q <= swf2_sum[64] ? {64{1'b1}} : swf2_sum[63:0];
          state_q   <= in_q.last ? F_START : S_IDLE;
        end
        // ---- shared divider, one quotient bit a cycle
        S_DIV: begin
          rem_q  <= q_bit ? 64'(rem_sh - {1'b0, dsr_q}) : rem_sh[63:0];
          dv_q   <= {dv_q[126:0], q_bit};
          dcnt_q <= dcnt_q - 8'd1;
          if (dcnt_q == 8'd1) begin
            state_q <= ret_q;
          end
        end
        // ---- shared squarer: x0^2 + 2 x0 x1 2^32 + x1^2 2^64
        SQ_A: state_q <= SQ_B;
        SQ_B: begin
          acc_q   <= 128'(p_q);
          state_q <= SQ_C;
        end
        SQ_C: begin
          acc_q   <= acc_q + (128'(p_q) << 33);
          state_q <= SQ_D;
        end
        SQ_D: begin
          acc_q   <= acc_q + (128'(p_q) << 64);
          state_q <= ret_q;
        end
        // ---- closing sequence
        F_START: begin
          dv_q    <= {sf_mag, 64'd0};
          rem_q   <= '0;
          dsr_q   <= 64'(count_q);
          dcnt_q  <= 8'd64;
          ret_q   <= F_MEAN_DONE;
          state_q <= S_DIV;
        end
        F_MEAN_DONE: begin
          mean_q  <= sum_flux_q[SF_W-1] ? (24'd0 - dv_q[23:0]) : dv_q[23:0];
          x_q     <= sf_mag;
          ret_q   <= F_VAR_Q;
          state_q <= SQ_A;
        end
        F_VAR_Q: begin
          dv_q    <= acc_q;
          rem_q   <= '0;
          dsr_q   <= 64'(count_q);
          dcnt_q  <= 8'd128;
          ret_q   <= F_VAR_DIFF;
          state_q <= S_DIV;
        end
        F_VAR_DIFF: begin
          if ((count_q > CNT_W'(1)) && (dv_q[63:0] < sxx64)) begin
            dv_q    <= {sxx64 - dv_q[63:0], 64'd0};
            rem_q   <= '0;
            dsr_q   <= 64'(count_q - CNT_W'(1));
            dcnt_q  <= 8'd64;
            ret_q   <= F_VAR_DONE;
            state_q <= S_DIV;
          end else begin
            var_q   <= '0;
            state_q <= F_IDX;
          end
        end
        F_VAR_DONE: begin
          var_q   <= dv_q[62:0];
          state_q <= F_IDX;
        end
        F_IDX: begin
          if (sum_w_q == '0) begin
            idx_q   <= sum_wf2_q;
            state_q <= F_OUT;
          end else begin
            x_q     <= swf_mag;
            ret_q   <= F_IDX_Q;
            state_q <= SQ_A;
          end
        end
        F_IDX_Q: begin
          dv_q    <= acc_q;
          rem_q   <= '0;
          dsr_q   <= 64'(sum_w_q);
          dcnt_q  <= 8'd128;
          ret_q   <= F_IDX_DONE;
          state_q <= S_DIV;
        end
        F_IDX_DONE: begin
          idx_q   <= idx_new;
          state_q <= F_OUT;
        end
        // result waits here only while the output register is still full
        F_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q                <= 1'b1;
            out_q.point_count          <= PC_W'(count_q);
            out_q.mean_flux            <= (count_q == '0) ? 24'sd0 : $signed(mean_q);
            out_q.mean_valid           <= (count_q != '0);
            out_q.flux_variance        <= var_q;
            out_q.variability_index    <= idx_q[63] ? {63{1'b1}} : idx_q[62:0];
            out_q.weight_saturated     <= sat_q;
            count_q       <= '0;
            sum_flux_q    <= '0;
            sum_flux_sq_q <= '0;
            sum_w_q       <= '0;
            sum_wf_q      <= '0;
            sum_wf2_q     <= '0;
            sat_q         <= 1'b0;
            state_q       <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
